### hdl/pbo_pkg.sv
// ----------------------------------------------------------------------------
// pbo_pkg
// Shared types and constants for the pulse/blink output controller.
// ----------------------------------------------------------------------------
package pbo_pkg;

    typedef enum logic [2:0] {
        CMD_TICK  = 3'd0,
        CMD_PULSE = 3'd1,
        CMD_BLINK = 3'd2,
        CMD_DUTY  = 3'd3,
        CMD_STOP  = 3'd4
    } t_cmd;

    typedef enum logic [1:0] {
        MODE_IDLE  = 2'd0,
        MODE_PULSE = 2'd1,
        MODE_BLINK = 2'd2
    } t_mode;

    localparam logic [15:0] Q8_ONE = 16'd256;

    typedef struct packed {
        logic [2:0]         command;
        logic [31:0]        first_time_ms;
        logic [31:0]        second_time_ms;
        logic [15:0]        duty_fraction;
        logic signed [7:0]  cycle_request;
    } t_cmd_item;

    // handshake between the input register and the core
    typedef struct packed {
        logic valid;
        logic ready;
    } t_hs;

endpackage

### hdl/pbo_ifs.sv
// ----------------------------------------------------------------------------
// pbo channel interfaces
// Command channel and result channel, valid/ready with payload.
// ----------------------------------------------------------------------------
interface pbo_cmd_if;
    logic               valid;
    logic               ready;
    logic [2:0]         command;
    logic [31:0]        first_time_ms;
    logic [31:0]        second_time_ms;
    logic [15:0]        duty_fraction;
    logic signed [7:0]  cycle_request;

    modport source (
        output valid, command, first_time_ms, second_time_ms, duty_fraction,
               cycle_request,
        input  ready
    );
    modport sink (
        input  valid, command, first_time_ms, second_time_ms, duty_fraction,
               cycle_request,
        output ready
    );
endinterface

interface pbo_res_if;
    logic       valid;
    logic       ready;
    logic       pin_level;
    logic [1:0] mode_now;
    logic [6:0] cycles_left;

    modport source (
        output valid, pin_level, mode_now, cycles_left,
        input  ready
    );
    modport sink (
        input  valid, pin_level, mode_now, cycles_left,
        output ready
    );
endinterface

### hdl/pbo_in_stage.sv
// ----------------------------------------------------------------------------
// pbo_in_stage
// Input register for the command channel; refills in the cycle it drains.
// ----------------------------------------------------------------------------
module pbo_in_stage
    import pbo_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    pbo_cmd_if.sink     i_cmd,
    output t_cmd_item   o_item,
    output logic        o_valid,
    input  logic        i_take
);

    logic      r_valid;
    t_cmd_item r_item;
    logic      w_load;

    assign i_cmd.ready = !r_valid || i_take;
    assign w_load      = i_cmd.valid && i_cmd.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_load) begin
            r_valid <= 1'b1;
        end else if (i_take) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_item.command        <= i_cmd.command;
            r_item.first_time_ms  <= i_cmd.first_time_ms;
            r_item.second_time_ms <= i_cmd.second_time_ms;
            r_item.duty_fraction  <= i_cmd.duty_fraction;
            r_item.cycle_request  <= i_cmd.cycle_request;
        end
    end

    assign o_item  = r_item;
    assign o_valid = r_valid;

endmodule

### hdl/pbo_core.sv
// ----------------------------------------------------------------------------
// pbo_core
// Timer state, command decode and result register.
// ----------------------------------------------------------------------------
module pbo_core
    import pbo_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_active_level,
    input  t_cmd_item   i_item,
    output t_hs         o_hs,
    input  logic        i_valid,
    pbo_res_if.source   o_res
);

    // Elapsed time since the mark is kept instead of clock and mark;
    // only their wrapped difference is ever observed.
    logic [31:0] r_elapsed,   n_elapsed;
    logic [31:0] r_pulse_len, n_pulse_len;
    logic [31:0] r_on_len,    n_on_len;
    logic [31:0] r_off_len,   n_off_len;
    logic        r_lit,       n_lit;
    logic        r_pulse_act, n_pulse_act;
    logic        r_blink_act, n_blink_act;
    logic        r_counted,   n_counted;
    logic [6:0]  r_count,     n_count;

    logic        r_out_valid;
    logic        r_pin;
    t_mode       r_mode;
    logic [6:0]  r_left;

    logic        w_take;
    logic [31:0] w_e_inc;
    logic [8:0]  w_q;
    logic [40:0] w_prod;
    logic [31:0] w_duty_on;
    logic [31:0] w_blink_on;
    logic [31:0] w_blink_off;
    logic        w_cyc_pos;
    logic [6:0]  w_count_dec;
    t_mode       w_mode;

    assign w_take      = i_valid && (!r_out_valid || o_res.ready);
    assign o_hs.valid  = i_valid;
    assign o_hs.ready  = w_take;

    assign w_e_inc     = r_elapsed + 32'd1;
    assign w_q         = (i_item.duty_fraction > Q8_ONE) ? Q8_ONE[8:0]
                                                         : i_item.duty_fraction[8:0];
    assign w_prod      = 41'(i_item.first_time_ms) * 41'(w_q);
    assign w_duty_on   = w_prod[39:8];
    assign w_cyc_pos   = !i_item.cycle_request[7] && (i_item.cycle_request != 8'sd0);
    assign w_count_dec = r_count - 7'd1;

    always_comb begin
        w_blink_on  = i_item.first_time_ms;
        w_blink_off = i_item.second_time_ms;
        if (t_cmd'(i_item.command) == CMD_DUTY) begin
            w_blink_on  = w_duty_on;
            w_blink_off = i_item.first_time_ms - w_duty_on;
        end
    end

    always_comb begin
        n_elapsed   = r_elapsed;
        n_pulse_len = r_pulse_len;
        n_on_len    = r_on_len;
        n_off_len   = r_off_len;
        n_lit       = r_lit;
        n_pulse_act = r_pulse_act;
        n_blink_act = r_blink_act;
        n_counted   = r_counted;
        n_count     = r_count;
        unique case (t_cmd'(i_item.command))
            CMD_TICK: begin
                n_elapsed = w_e_inc;
                if (r_pulse_act) begin
                    if (w_e_inc >= r_pulse_len) begin
                        n_pulse_act = 1'b0;
                        n_lit       = 1'b0;
                    end
                end else if (r_blink_act) begin
                    if (r_lit && w_e_inc >= r_on_len) begin
                        n_lit     = 1'b0;
                        n_elapsed = '0;
                    end else if (!r_lit && w_e_inc >= r_off_len) begin
                        n_lit     = 1'b1;
                        n_elapsed = '0;
                        if (r_counted) begin
                            n_count = w_count_dec;
                            if (w_count_dec == 7'd0) begin
                                n_blink_act = 1'b0;
                                n_counted   = 1'b0;
                                n_lit       = 1'b0;
                            end
                        end
                    end
                end
            end
            CMD_PULSE: begin
                if (!r_pulse_act) begin
                    n_pulse_act = 1'b1;
                    n_blink_act = 1'b0;
                    n_counted   = 1'b0;
                    n_count     = '0;
                    n_pulse_len = i_item.first_time_ms;
                    n_elapsed   = '0;
                    n_lit       = 1'b1;
                end
            end
            CMD_BLINK, CMD_DUTY: begin
                if (!r_blink_act) begin
                    n_pulse_act = 1'b0;
                    n_blink_act = 1'b1;
                    n_counted   = w_cyc_pos;
                    n_count     = w_cyc_pos ? i_item.cycle_request[6:0] : 7'd0;
                    n_on_len    = w_blink_on;
                    n_off_len   = w_blink_off;
                    n_elapsed   = '0;
                    n_lit       = 1'b1;
                end
            end
            CMD_STOP: begin
                n_pulse_act = 1'b0;
                n_blink_act = 1'b0;
                n_counted   = 1'b0;
                n_count     = '0;
                n_lit       = 1'b0;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        if (n_pulse_act) begin
            w_mode = MODE_PULSE;
        end else if (n_blink_act) begin
            w_mode = MODE_BLINK;
        end else begin
            w_mode = MODE_IDLE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_elapsed   <= '0;
            r_pulse_len <= '0;
            r_on_len    <= '0;
            r_off_len   <= '0;
            r_lit       <= 1'b0;
            r_pulse_act <= 1'b0;
            r_blink_act <= 1'b0;
            r_counted   <= 1'b0;
            r_count     <= '0;
        end else if (w_take) begin
            r_elapsed   <= n_elapsed;
            r_pulse_len <= n_pulse_len;
            r_on_len    <= n_on_len;
            r_off_len   <= n_off_len;
            r_lit       <= n_lit;
            r_pulse_act <= n_pulse_act;
            r_blink_act <= n_blink_act;
            r_counted   <= n_counted;
            r_count     <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_take) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_pin  <= n_lit ? i_active_level : !i_active_level;
            r_mode <= w_mode;
            r_left <= n_counted ? n_count : 7'd0;
        end
    end

    assign o_res.valid       = r_out_valid;
    assign o_res.pin_level   = r_pin;
    assign o_res.mode_now    = r_mode;
    assign o_res.cycles_left = r_left;

    a_one_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_pulse_act && r_blink_act))
        else $error("pulse and blink active together");

    a_counted_in_blink: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_counted |-> (r_blink_act && r_count != 7'd0))
        else $error("counted blink without blink or with zero count");

    a_idle_unlit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!r_pulse_act && !r_blink_act) |-> !r_lit)
        else $error("pin lit while idle");

    a_result_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_res.ready) |=> (r_out_valid && $stable(r_mode)
                                          && $stable(r_left) && $stable(r_pin)))
        else $error("stalled result changed");

endmodule

### hdl/pulse_blink_output_controller.sv
// ----------------------------------------------------------------------------
// pulse_blink_output_controller
// Drives one output pin from a command stream of ticks, pulses and blinks.
// ----------------------------------------------------------------------------
// Usage:
//   i_cmd  : command channel (tick, pulse, blink, duty blink, stop), one
//            result transfer on o_res for every command transfer.
//   o_res  : pin level, mode and remaining counted cycles after the command.
//   i_cfg_we / i_cfg_data : writes the active pin level (reset value 1);
//            write only while no command is in flight.
// Path: a result passes through the input register, then the state update
//   into the result register, before it can transfer on o_res.
// Throughput: one command per cycle while o_res is not held; the state update is a single
//   add-and-compare or a 32x9 multiply for the duty split.
// Reset: lit state off, idle, elapsed time zero, both channels empty.
// Stall: while o_res is held, one more command fills the input register;
//   after that i_cmd.ready drops until the result is taken.
// ----------------------------------------------------------------------------
module pulse_blink_output_controller
    import pbo_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_data,
    pbo_cmd_if.sink     i_cmd,
    pbo_res_if.source   o_res
);

    logic      r_active_level;
    t_cmd_item w_item;
    logic      w_valid;
    t_hs       w_hs;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active_level <= 1'b1;
        end else if (i_cfg_we) begin
            r_active_level <= i_cfg_data;
        end
    end

    pbo_in_stage u_in (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (i_cmd),
        .o_item  (w_item),
        .o_valid (w_valid),
        .i_take  (w_hs.ready)
    );

    pbo_core u_core (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_active_level (r_active_level),
        .i_item         (w_item),
        .o_hs           (w_hs),
        .i_valid        (w_valid),
        .o_res          (o_res)
    );

endmodule

### verif/pulse_blink_output_controller_test.sv
// ----------------------------------------------------------------------------
// pulse_blink_output_controller_test
// Drives command transfers (ticks, pulses, blinks, duty blinks, stops and
// unused codes) with bursty valid and a patterned result stall. A pin model
// predicts the pin level, mode and remaining cycles after every command and
// each result transfer is checked against it. The active level is changed
// between phases while no command is in flight.
// ----------------------------------------------------------------------------
module pulse_blink_output_controller_test;
    import pbo_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [2:0] CMD_RSVD_LO = 3'd5;
    localparam logic [2:0] CMD_RSVD_HI = 3'd7;
    localparam int unsigned CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic        pin_level;
        t_mode       mode_now;
        logic [6:0]  cycles_left;
    } t_pin_view;

    logic i_clk;
    logic i_rst_n;
    logic cfg_we;
    logic cfg_data;

    pbo_cmd_if cmd_ch ();
    pbo_res_if res_ch ();

    pulse_blink_output_controller u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_data (cfg_data),
        .i_cmd      (cmd_ch),
        .o_res      (res_ch)
    );

    // pin model state
    logic [31:0] clk_ms;
    logic [31:0] mark_ms;
    logic [31:0] pulse_len;
    logic [31:0] on_len;
    logic [31:0] off_len;
    logic        lit;
    logic        pulse_run;
    logic        blink_run;
    logic        counted;
    logic [6:0]  cyc_left;
    logic        act_level;

    t_cmd_item   cmd_backlog[$];
    t_pin_view   pin_forecast[$];

    int unsigned counted_items;
    int unsigned fail_cnt;
    int unsigned cycle_cnt;
    bit          cmd_taken;
    int unsigned burst_left;
    int unsigned gap_left;
    int unsigned stall_left;
    int unsigned stall_mode;
    logic [15:0] stall_pat;

    // ------------------------------------------------------------------------
    // pin model
    // ------------------------------------------------------------------------
    task automatic go_idle();
        pulse_run = 1'b0;
        blink_run = 1'b0;
        counted   = 1'b0;
        cyc_left  = '0;
        lit       = 1'b0;
    endtask

    task automatic start_blink(input logic [31:0] on_ms, input logic [31:0] off_ms,
                               input logic signed [7:0] cyc);
        go_idle();
        blink_run = 1'b1;
        counted   = (cyc > 8'sd0);
        cyc_left  = counted ? cyc[6:0] : 7'd0;
        on_len    = on_ms;
        off_len   = off_ms;
        mark_ms   = clk_ms;
        lit       = 1'b1;
    endtask

    task automatic step_pin_model(input t_cmd_item it);
        logic [31:0] elapsed;
        logic [15:0] q;
        logic [47:0] prod;
        t_pin_view   view;
        case (it.command)
            CMD_TICK: begin
                clk_ms  = clk_ms + 32'd1;
                elapsed = clk_ms - mark_ms;
                if (pulse_run) begin
                    if (elapsed >= pulse_len)
                        go_idle();
                end else if (blink_run) begin
                    if (lit && elapsed >= on_len) begin
                        lit     = 1'b0;
                        mark_ms = clk_ms;
                    end else if (!lit && elapsed >= off_len) begin
                        lit     = 1'b1;
                        mark_ms = clk_ms;
                        if (counted) begin
                            cyc_left = cyc_left - 7'd1;
                            if (cyc_left == 7'd0)
                                go_idle();
                        end
                    end
                end
            end
            CMD_PULSE: begin
                if (!pulse_run) begin
                    go_idle();
                    pulse_run = 1'b1;
                    pulse_len = it.first_time_ms;
                    mark_ms   = clk_ms;
                    lit       = 1'b1;
                end
            end
            CMD_BLINK: begin
                if (!blink_run)
                    start_blink(it.first_time_ms, it.second_time_ms, it.cycle_request);
            end
            CMD_DUTY: begin
                if (!blink_run) begin
                    q    = (it.duty_fraction > Q8_ONE) ? Q8_ONE : it.duty_fraction;
                    prod = {16'd0, it.first_time_ms} * {32'd0, q};
                    start_blink(prod[39:8], it.first_time_ms - prod[39:8], it.cycle_request);
                end
            end
            CMD_STOP: go_idle();
            default: ;
        endcase
        view.pin_level   = lit ? act_level : ~act_level;
        view.mode_now    = pulse_run ? MODE_PULSE : (blink_run ? MODE_BLINK : MODE_IDLE);
        view.cycles_left = counted ? cyc_left : 7'd0;
        pin_forecast.push_back(view);
    endtask

    // ------------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------------
    task automatic queue_cmd(input logic [2:0] c, input logic [31:0] a,
                             input logic [31:0] b, input logic [15:0] d,
                             input logic [7:0] n);
        t_cmd_item it;
        it.command        = c;
        it.first_time_ms  = a;
        it.second_time_ms = b;
        it.duty_fraction  = d;
        it.cycle_request  = n;
        cmd_backlog.push_back(it);
        if (c <= CMD_STOP)
            counted_items++;
    endtask

    function automatic logic [31:0] pick_ms(input int unsigned hi);
        if ($urandom_range(0, 99) < 85)
            return $urandom_range(0, hi);
        return $urandom;
    endfunction

    function automatic logic [7:0] pick_cycles();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 8'($urandom_range(1, 6));
        if (r < 75)
            return ($urandom_range(0, 3) == 0) ? 8'd0 : 8'($urandom_range(128, 255));
        if (r < 85)
            return 8'($urandom_range(100, 127));
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic logic [15:0] pick_duty();
        if ($urandom_range(0, 99) < 70)
            return 16'($urandom_range(0, 300));
        return 16'($urandom_range(0, 65535));
    endfunction

    // a random command followed by a run of ticks, with some noise mixed in
    task automatic queue_random(input int unsigned n);
        int unsigned stop_at;
        int unsigned r;
        int unsigned ticks;
        stop_at = counted_items + n;
        while (counted_items < stop_at) begin
            r = $urandom_range(0, 99);
            if (r < 30)
                queue_cmd(CMD_PULSE, pick_ms(12), $urandom, pick_duty(), pick_cycles());
            else if (r < 60)
                queue_cmd(CMD_BLINK, pick_ms(6), pick_ms(6), pick_duty(), pick_cycles());
            else if (r < 80)
                queue_cmd(CMD_DUTY, pick_ms(16), $urandom, pick_duty(), pick_cycles());
            else if (r < 88)
                queue_cmd(CMD_STOP, $urandom, $urandom, pick_duty(), pick_cycles());
            else if (r < 93)
                queue_cmd(3'($urandom_range(CMD_RSVD_LO, CMD_RSVD_HI)), $urandom, $urandom,
                          pick_duty(), pick_cycles());
            else
                queue_cmd(3'($urandom_range(0, 7)), pick_ms(8), pick_ms(8), pick_duty(),
                          pick_cycles());
            ticks = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 12) : $urandom_range(0, 40);
            repeat (ticks) begin
                if ($urandom_range(0, 99) < 8)
                    queue_cmd(3'($urandom_range(0, 7)), pick_ms(8), pick_ms(8), pick_duty(),
                              pick_cycles());
                else
                    queue_cmd(CMD_TICK, $urandom, $urandom, 16'($urandom_range(0, 65535)),
                              8'($urandom_range(0, 255)));
            end
        end
    endtask

    task automatic wait_drained();
        while (cmd_backlog.size() != 0 || cmd_ch.valid || pin_forecast.size() != 0)
            @(negedge i_clk);
    endtask

    task automatic set_active_level(input logic lvl);
        @(negedge i_clk);
        cfg_we   <= 1'b1;
        cfg_data <= lvl;
        @(negedge i_clk);
        cfg_we   <= 1'b0;
        act_level = lvl;
    endtask

    // ------------------------------------------------------------------------
    // clock, reset, phases
    // ------------------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        i_rst_n               = 1'b0;
        cfg_we                = 1'b0;
        cfg_data              = 1'b0;
        cmd_ch.valid          = 1'b0;
        cmd_ch.command        = '0;
        cmd_ch.first_time_ms  = '0;
        cmd_ch.second_time_ms = '0;
        cmd_ch.duty_fraction  = '0;
        cmd_ch.cycle_request  = '0;
        res_ch.ready          = 1'b0;
        act_level             = 1'b1;
        clk_ms                = '0;
        mark_ms               = '0;
        pulse_len             = '0;
        on_len                = '0;
        off_len               = '0;
        go_idle();
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed, under the reset active level
        queue_cmd(CMD_TICK, 32'd0, 32'd0, 16'd0, 8'd0);
        queue_cmd(CMD_RSVD_LO, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 8'hFF);
        queue_cmd(CMD_PULSE, 32'd0, 32'd0, 16'd0, 8'd0);          // zero length pulse
        queue_cmd(CMD_TICK, 32'd0, 32'd0, 16'd0, 8'd0);
        queue_cmd(CMD_PULSE, 32'd2, 32'd0, 16'd0, 8'd0);
        queue_cmd(CMD_PULSE, 32'hFFFF_FFFF, 32'd0, 16'd0, 8'd0);  // ignored, pulse running
        queue_cmd(CMD_TICK, 32'd0, 32'd0, 16'd0, 8'd0);
        queue_cmd(CMD_TICK, 32'd0, 32'd0, 16'd0, 8'd0);
        queue_cmd(CMD_BLINK, 32'd0, 32'd0, 16'd0, 8'd2);          // zero phases, two counted blinks
        queue_cmd(CMD_TICK, 32'd0, 32'd0, 16'd0, 8'd0);
        queue_cmd(CMD_TICK, 32'd0, 32'd0, 16'd0, 8'd0);
        queue_cmd(CMD_BLINK, 32'd1, 32'd1, 16'd0, 8'h80);         // ignored, blinking
        queue_cmd(CMD_TICK, 32'd0, 32'd0, 16'd0, 8'd0);
        queue_cmd(CMD_TICK, 32'd0, 32'd0, 16'd0, 8'd0);
        queue_cmd(CMD_DUTY, 32'hFFFF_FFFF, 32'd0, 16'hFFFF, 8'hFF); // clamped, forever
        queue_cmd(CMD_PULSE, 32'd3, 32'd0, 16'd0, 8'd0);          // cuts the blink short
        queue_cmd(CMD_DUTY, 32'd10, 32'd0, 16'd128, 8'd127);      // cuts the pulse short
        queue_cmd(CMD_STOP, 32'd0, 32'd0, 16'd0, 8'd0);
        queue_cmd(CMD_DUTY, 32'd7, 32'd0, 16'd256, 8'd0);         // full on, forever
        queue_cmd(CMD_TICK, 32'd0, 32'd0, 16'd0, 8'd0);
        queue_cmd(CMD_DUTY, 32'd7, 32'd0, 16'd0, 8'h7F);          // ignored, blinking
        queue_cmd(CMD_RSVD_HI, 32'd0, 32'd0, 16'd0, 8'd0);
        queue_cmd(CMD_STOP, 32'd0, 32'd0, 16'd0, 8'd0);
        queue_cmd(CMD_BLINK, 32'hFFFF_FFFF, 32'hAAAA_5555, 16'h5555, 8'h55);
        queue_cmd(CMD_STOP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 8'hFF);
        queue_random(150);
        wait_drained();

        set_active_level(1'b0);
        queue_random(150);
        wait_drained();

        set_active_level(1'b1);
        queue_random(150);
        wait_drained();

        set_active_level(1'b0);
        queue_random(150);
        wait_drained();

        repeat (8) @(posedge i_clk);
        fail_cnt += pin_forecast.size();
        if (fail_cnt == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    // ------------------------------------------------------------------------
    // command driver: bursts with random gaps
    // ------------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            cmd_ch.valid <= 1'b0;
            burst_left = 0;
            gap_left   = 0;
        end else if (!(cmd_ch.valid && !cmd_taken)) begin
            if (cmd_taken) begin
                void'(cmd_backlog.pop_front());
                cmd_taken = 1'b0;
            end
            if (gap_left != 0) begin
                gap_left--;
                cmd_ch.valid <= 1'b0;
            end else if (cmd_backlog.size() != 0) begin
                cmd_ch.valid          <= 1'b1;
                cmd_ch.command        <= cmd_backlog[0].command;
                cmd_ch.first_time_ms  <= cmd_backlog[0].first_time_ms;
                cmd_ch.second_time_ms <= cmd_backlog[0].second_time_ms;
                cmd_ch.duty_fraction  <= cmd_backlog[0].duty_fraction;
                cmd_ch.cycle_request  <= cmd_backlog[0].cycle_request;
                if (burst_left <= 1) begin
                    burst_left = $urandom_range(1, 24);
                    case ($urandom_range(0, 9))
                        0, 1, 2:    gap_left = 0;
                        8, 9:       gap_left = $urandom_range(5, 20);
                        default:    gap_left = $urandom_range(1, 4);
                    endcase
                end else begin
                    burst_left--;
                end
            end else begin
                cmd_ch.valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // result receiver: the stall pattern is redrawn whenever its run counter expires
    // ------------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            res_ch.ready <= 1'b0;
            stall_left = 0;
        end else begin
            if (stall_left == 0) begin
                stall_mode = $urandom_range(0, 3);
                stall_left = $urandom_range(16, 80);
                stall_pat  = 16'($urandom_range(1, 65535));
            end else begin
                stall_left--;
            end
            case (stall_mode)
                0: res_ch.ready <= 1'b1;
                1: res_ch.ready <= ($urandom_range(0, 9) < 7);
                2: begin
                    res_ch.ready <= stall_pat[0];
                    stall_pat = {stall_pat[0], stall_pat[15:1]};
                end
                default: res_ch.ready <= ($urandom_range(0, 15) == 0);
            endcase
        end
    end

    // ------------------------------------------------------------------------
    // accepted commands feed the model; result transfers are checked
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_cmd_item acc;
        t_pin_view want;
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_cnt);
            $display("Test completed with failures");
            $finish;
        end
        if (i_rst_n && cmd_ch.valid && cmd_ch.ready) begin
            acc.command        = cmd_ch.command;
            acc.first_time_ms  = cmd_ch.first_time_ms;
            acc.second_time_ms = cmd_ch.second_time_ms;
            acc.duty_fraction  = cmd_ch.duty_fraction;
            acc.cycle_request  = cmd_ch.cycle_request;
            step_pin_model(acc);
            cmd_taken = 1'b1;
        end
        if (i_rst_n && res_ch.valid === 1'b1 && res_ch.ready) begin
            if (pin_forecast.size() == 0) begin
                fail_cnt++;
                if (fail_cnt <= 10)
                    $display("unexpected result transfer: pin %b mode %0d left %0d",
                             res_ch.pin_level, res_ch.mode_now, res_ch.cycles_left);
            end else begin
                want = pin_forecast.pop_front();
                if (res_ch.pin_level !== want.pin_level || res_ch.mode_now !== want.mode_now
                        || res_ch.cycles_left !== want.cycles_left) begin
                    fail_cnt++;
                    if (fail_cnt <= 10)
                        $display("mismatch at cycle %0d: pin %b/%b mode %0d/%0d left %0d/%0d",
                                 cycle_cnt, want.pin_level, res_ch.pin_level,
                                 want.mode_now, res_ch.mode_now,
                                 want.cycles_left, res_ch.cycles_left);
                end
            end
        end
    end

endmodule
